// ===== rtl/core/dda_pkg.sv =====
`default_nettype none

package dda_pkg;

   // coordinate and fixed-point geometry
   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;

   // frame geometry registers and frame-buffer address
   localparam int DIM_BITS   = 11;
   localparam int ADDR_BITS  = 20;
   localparam int COLOR_BITS = 32;

   // accumulators hold a coordinate, the fraction, and sign plus headroom
   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 2;
   // increment magnitude is at most one whole pixel
   localparam int QUO_BITS  = FRAC_BITS + 1;
   localparam int STEP_BITS = FRAC_BITS + 2;
   localparam int CNT_BITS  = $clog2(FRAC_BITS + 1);
   localparam int MUL_BITS  = COORD_BITS + DIM_BITS;

   localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(640);
   localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(480);

   // command codes
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   // register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/dda_if.sv =====
`default_nettype none

interface dda_req_if import dda_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    command;
   logic [COORD_BITS-1:0]   start_x;
   logic [COORD_BITS-1:0]   start_y;
   logic [COORD_BITS-1:0]   end_x;
   logic [COORD_BITS-1:0]   end_y;
   logic [COLOR_BITS-1:0]   line_color;

   modport source (output valid, command, start_x, start_y, end_x, end_y, line_color,
                   input ready);
   modport sink   (input valid, command, start_x, start_y, end_x, end_y, line_color,
                   output ready);
endinterface

interface dda_rsp_if import dda_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [COORD_BITS-1:0]   pixel_x;
   logic [COORD_BITS-1:0]   pixel_y;
   logic [ADDR_BITS-1:0]    pixel_address;
   logic [COLOR_BITS-1:0]   pixel_color;
   logic                    in_bounds;
   logic                    last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, in_bounds,
                   last_pixel, input ready);
   modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color, in_bounds,
                   last_pixel, output ready);
endinterface

interface dda_csr_if import dda_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [CSR_INDEX_BITS-1:0]   index;
   logic [DIM_BITS-1:0]         data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/dda_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle: (dividend << FRAC_BITS) / divisor
// dividend must not exceed divisor, divisor nonzero
module dda_div import dda_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COORD_BITS-1:0] dividend,
   input  wire logic [COORD_BITS-1:0] divisor,
   output      logic [QUO_BITS-1:0]   quotient,
   output      div_status_type        status
);

   logic [COORD_BITS:0]   rem_ff, rem_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] den_ff, den_in;
   logic                  first_ff, first_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [COORD_BITS:0]   trial;
   logic                  fits;

   // first bit uses the dividend as is, later bits shift the remainder
   always_comb begin
      trial  = first_ff ? rem_ff : {rem_ff[COORD_BITS-1:0], 1'b0};
      fits   = trial >= {1'b0, den_ff};
   end

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      den_in   = den_ff;
      first_in = first_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = {1'b0, dividend};
         quo_in   = '0;
         cnt_in   = CNT_BITS'(FRAC_BITS);
         den_in   = divisor;
         first_in = 1'b1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? trial - {1'b0, den_ff} : trial;
         quo_in   = {quo_ff[QUO_BITS-2:0], fits};
         first_in = 1'b0;
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      den_ff   <= den_in;
      first_ff <= first_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

// ===== rtl/core/dda_line_pixel_generator_top.sv =====
`default_nettype none

// start command: no result; for a line of nonzero length the input is held off after
//   the transfer while the shared bit-serial divider forms the x increment and then
//   the y increment
// step command with a pixel pending: result registered, valid in the next cycle;
//   one pixel per cycle sustained while the result side keeps taking them
// reset (synchronous, active high): no line pending, width 640, height 480
module dda_line_pixel_generator_top import dda_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   dda_req_if.sink   req_chan,
   dda_rsp_if.source rsp_chan,
   dda_csr_if.sink   csr_chan
);

   // sign applied to an unsigned quotient
   function automatic logic signed [STEP_BITS-1:0] apply_sign(
      input logic [QUO_BITS-1:0] mag,
      input logic                neg
   );
      logic signed [STEP_BITS-1:0] val;
      val = signed'({1'b0, mag});
      return neg ? -val : val;
   endfunction

   // round half up, clamp below zero
   function automatic logic [COORD_BITS-1:0] round_coord(
      input logic signed [ACC_BITS-1:0] acc
   );
      logic signed [ACC_BITS-1:0] sum;
      sum = acc + ACC_BITS'(1 << (FRAC_BITS - 1));
      return sum[ACC_BITS-1] ? '0 : sum[FRAC_BITS+COORD_BITS-1:FRAC_BITS];
   endfunction

   state_type state_ff, state_in;

   // frame geometry registers
   logic [DIM_BITS-1:0] width_ff, height_ff;

   // line state
   logic signed [ACC_BITS-1:0]  acc_x_ff, acc_y_ff;
   logic signed [STEP_BITS-1:0] step_x_ff, step_y_ff;
   logic [COORD_BITS-1:0]       steps_left_ff;
   logic [COLOR_BITS-1:0]       held_color_ff;
   logic [COORD_BITS-1:0]       mag_y_ff;
   logic                        neg_x_ff, neg_y_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [COORD_BITS-1:0] pixel_x_ff, pixel_y_ff;
   logic [ADDR_BITS-1:0]  pixel_address_ff;
   logic [COLOR_BITS-1:0] pixel_color_ff;
   logic                  in_bounds_ff, last_pixel_ff;

   // transfers
   logic req_fire, start_fire, step_fire;

   // start command decode
   logic                  neg_x, neg_y;
   logic [COORD_BITS-1:0] mag_x, mag_y, line_len;

   // pixel datapath
   logic [COORD_BITS-1:0] px, py;
   logic [MUL_BITS-1:0]   row_base;
   logic [ADDR_BITS-1:0]  address;
   logic                  in_frame;

   // shared divider
   logic                  div_start;
   logic [COORD_BITS-1:0] div_dividend, div_divisor;
   logic [QUO_BITS-1:0]   div_quotient;
   div_status_type        div_status;

   // ------------------------------------------------------------------
   // handshakes: input taken only when idle and the result slot frees up
   // ------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign start_fire     = req_fire && (req_chan.command == CMD_START);
   // a step with nothing pending is taken and dropped
   assign step_fire      = req_fire && (req_chan.command == CMD_STEP) && (steps_left_ff != '0);

   assign csr_chan.ready = 1'b1;

   // ------------------------------------------------------------------
   // start command: axis deltas as sign and magnitude, longer one is the count
   // ------------------------------------------------------------------
   always_comb begin
      neg_x    = req_chan.end_x < req_chan.start_x;
      neg_y    = req_chan.end_y < req_chan.start_y;
      mag_x    = neg_x ? req_chan.start_x - req_chan.end_x : req_chan.end_x - req_chan.start_x;
      mag_y    = neg_y ? req_chan.start_y - req_chan.end_y : req_chan.end_y - req_chan.start_y;
      line_len = (mag_x >= mag_y) ? mag_x : mag_y;
   end

   // ------------------------------------------------------------------
   // pixel datapath: round, then one multiply for the row base
   // ------------------------------------------------------------------
   always_comb begin
      px       = round_coord(acc_x_ff);
      py       = round_coord(acc_y_ff);
      row_base = MUL_BITS'(py) * MUL_BITS'(width_ff);
      address  = ADDR_BITS'(row_base + MUL_BITS'(px));
      in_frame = ({1'b0, px} < width_ff) && ({1'b0, py} < height_ff);
   end

   // ------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start_fire && (line_len != '0)) begin
               state_in = ST_DIV_X;
            end
         end
         ST_DIV_X: begin
            if (div_status.done) begin
               state_in = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_status.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer: divider controls
   // ------------------------------------------------------------------
   always_comb begin
      div_start    = 1'b0;
      div_dividend = mag_x;
      div_divisor  = line_len;
      unique case (state_ff)
         ST_IDLE: begin
            div_start = start_fire && (line_len != '0);
         end
         ST_DIV_X: begin
            // x done, reuse the unit for y
            div_start    = div_status.done;
            div_dividend = mag_y_ff;
            div_divisor  = steps_left_ff;
         end
         ST_DIV_Y: begin
            div_dividend = mag_y_ff;
            div_divisor  = steps_left_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   dda_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quotient),
      .status   (div_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // geometry registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_SCREEN_WIDTH:  width_ff  <= csr_chan.data;
            CSR_SCREEN_HEIGHT: height_ff <= csr_chan.data;
            default:           width_ff  <= width_ff;
         endcase
      end
   end

   // line state: latch on start, advance on each emitted pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_left_ff <= '0;
      end else if (start_fire) begin
         steps_left_ff <= line_len;
      end else if (step_fire) begin
         steps_left_ff <= steps_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start_fire) begin
         acc_x_ff      <= signed'(ACC_BITS'(req_chan.start_x) << FRAC_BITS);
         acc_y_ff      <= signed'(ACC_BITS'(req_chan.start_y) << FRAC_BITS);
         held_color_ff <= req_chan.line_color;
         mag_y_ff      <= mag_y;
         neg_x_ff      <= neg_x;
         neg_y_ff      <= neg_y;
         // zero-length line keeps zero increments
         step_x_ff     <= '0;
         step_y_ff     <= '0;
      end else begin
         if (step_fire) begin
            acc_x_ff <= acc_x_ff + ACC_BITS'(step_x_ff);
            acc_y_ff <= acc_y_ff + ACC_BITS'(step_y_ff);
         end
         if (div_status.done && (state_ff == ST_DIV_X)) begin
            step_x_ff <= apply_sign(div_quotient, neg_x_ff);
         end
         if (div_status.done && (state_ff == ST_DIV_Y)) begin
            step_y_ff <= apply_sign(div_quotient, neg_y_ff);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         pixel_x_ff       <= px;
         pixel_y_ff       <= py;
         pixel_address_ff <= address;
         pixel_color_ff   <= held_color_ff;
         in_bounds_ff     <= in_frame;
         last_pixel_ff    <= (steps_left_ff == COORD_BITS'(1));
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pixel_x       = pixel_x_ff;
   assign rsp_chan.pixel_y       = pixel_y_ff;
   assign rsp_chan.pixel_address = pixel_address_ff;
   assign rsp_chan.pixel_color   = pixel_color_ff;
   assign rsp_chan.in_bounds     = in_bounds_ff;
   assign rsp_chan.last_pixel    = last_pixel_ff;

`ifndef ASSERT_OFF
   // no input transfer while the divider is working on a line
   a_idle_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_chan.ready |-> (state_ff == ST_IDLE) && !div_status.busy)
      else $error("input taken while divider busy");

   // a division only runs for a line with a nonzero count
   a_div_has_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (steps_left_ff != '0))
      else $error("division running for zero-length line");

   // divider finishes only inside the division states
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV_X) || (state_ff == ST_DIV_Y))
      else $error("divider done outside sequence");

   // the pixel flagged last leaves no pixels pending
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (step_fire && (steps_left_ff == COORD_BITS'(1))) |=>
         (rsp_chan.valid && rsp_chan.last_pixel && (steps_left_ff == '0)))
      else $error("last pixel flag out of step with count");
`endif

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dda_pkg::*;

   // settle time after the last pixel: covers the divider of a start command
   localparam int DRAIN_CYCLES    = 2 * (FRAC_BITS + 2) + 12;
   // receiver hold-off used to fill the block and stall its input
   localparam int HOLD_OFF_CYCLES = 300;

   // one expected pixel transfer on the result side
   typedef struct packed {
      logic [COORD_BITS-1:0] pixel_x;
      logic [COORD_BITS-1:0] pixel_y;
      logic [ADDR_BITS-1:0]  pixel_address;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  in_bounds;
      logic                  last_pixel;
   } pixel_type;

   logic clock;
   logic reset;

   dda_req_if req_chan ();
   dda_rsp_if rsp_chan ();
   dda_csr_if csr_chan ();

   dda_line_pixel_generator_top i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // pixels predicted but not yet seen on the result side
   pixel_type expected_pixels[$];
   int        mismatch_count = 0;

   // traffic shaping, percent of cycles
   int   idle_pct  = 0;
   int   stall_pct = 0;
   logic hold_active;

   // predicted line state and frame geometry
   logic signed [ACC_BITS-1:0]  line_acc_x;
   logic signed [ACC_BITS-1:0]  line_acc_y;
   logic signed [STEP_BITS-1:0] line_inc_x;
   logic signed [STEP_BITS-1:0] line_inc_y;
   logic [DIM_BITS-1:0]         pixels_left;
   logic [COLOR_BITS-1:0]       line_color;
   logic [DIM_BITS-1:0]         frame_width;
   logic [DIM_BITS-1:0]         frame_height;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // per-axis increment: delta / length with FRAC_BITS fraction bits, truncated toward zero
   function automatic logic signed [STEP_BITS-1:0] dda_increment(input int delta, input int len);
      int mag;
      int quo;
      if (len == 0) begin
         return '0;
      end
      mag = (delta < 0) ? -delta : delta;
      quo = (mag << FRAC_BITS) / len;
      return STEP_BITS'((delta < 0) ? -quo : quo);
   endfunction

   // round half up to a whole pixel, clamp below zero
   function automatic logic [COORD_BITS-1:0] round_coordinate(
      input logic signed [ACC_BITS-1:0] acc);
      longint v;
      v = longint'(acc) + (longint'(1) << (FRAC_BITS - 1));
      if (v < 0) begin
         return '0;
      end
      return COORD_BITS'(v >>> FRAC_BITS);
   endfunction

   // update the predicted line state for one accepted command
   task automatic predict_pixel(input logic cmd,
                                input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
                                input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                                input logic [COLOR_BITS-1:0] color);
      int          dx;
      int          dy;
      int          len;
      int unsigned addr;
      pixel_type   px;
      if (cmd == CMD_START) begin
         dx  = int'(ex) - int'(sx);
         dy  = int'(ey) - int'(sy);
         len = ((dx < 0) ? -dx : dx) >= ((dy < 0) ? -dy : dy) ?
               ((dx < 0) ? -dx : dx) : ((dy < 0) ? -dy : dy);
         line_color  = color;
         line_acc_x  = ACC_BITS'(sx) <<< FRAC_BITS;
         line_acc_y  = ACC_BITS'(sy) <<< FRAC_BITS;
         line_inc_x  = dda_increment(dx, len);
         line_inc_y  = dda_increment(dy, len);
         pixels_left = DIM_BITS'(len);
      end else if (pixels_left != 0) begin
         px.pixel_x       = round_coordinate(line_acc_x);
         px.pixel_y       = round_coordinate(line_acc_y);
         addr             = int'(px.pixel_y) * int'(frame_width) + int'(px.pixel_x);
         px.pixel_address = ADDR_BITS'(addr);
         px.pixel_color   = line_color;
         px.in_bounds     = (px.pixel_x < frame_width) && (px.pixel_y < frame_height);
         px.last_pixel    = (pixels_left == 1);
         expected_pixels.push_back(px);
         line_acc_x  = line_acc_x + line_inc_x;
         line_acc_y  = line_acc_y + line_inc_y;
         pixels_left = pixels_left - 1'b1;
      end
   endtask

   // compare one pixel transfer with the oldest prediction
   task automatic check_pixel();
      pixel_type want;
      if (expected_pixels.size() == 0) begin
         $error("unexpected pixel x %0d y %0d", rsp_chan.pixel_x, rsp_chan.pixel_y);
         mismatch_count++;
      end else begin
         want = expected_pixels.pop_front();
         if (rsp_chan.pixel_x !== want.pixel_x) begin
            $error("pixel_x expected %0d actual %0d", want.pixel_x, rsp_chan.pixel_x);
            mismatch_count++;
         end
         if (rsp_chan.pixel_y !== want.pixel_y) begin
            $error("pixel_y expected %0d actual %0d", want.pixel_y, rsp_chan.pixel_y);
            mismatch_count++;
         end
         if (rsp_chan.pixel_address !== want.pixel_address) begin
            $error("pixel_address expected %0d actual %0d", want.pixel_address,
                   rsp_chan.pixel_address);
            mismatch_count++;
         end
         if (rsp_chan.pixel_color !== want.pixel_color) begin
            $error("pixel_color expected %h actual %h", want.pixel_color, rsp_chan.pixel_color);
            mismatch_count++;
         end
         if (rsp_chan.in_bounds !== want.in_bounds) begin
            $error("in_bounds expected %0d actual %0d", want.in_bounds, rsp_chan.in_bounds);
            mismatch_count++;
         end
         if (rsp_chan.last_pixel !== want.last_pixel) begin
            $error("last_pixel expected %0d actual %0d", want.last_pixel, rsp_chan.last_pixel);
            mismatch_count++;
         end
      end
   endtask

   // monitor: every transfer is seen here at the clock edge it happens on
   always @(posedge clock) begin
      if (reset) begin
         line_acc_x   = '0;
         line_acc_y   = '0;
         line_inc_x   = '0;
         line_inc_y   = '0;
         pixels_left  = '0;
         line_color   = '0;
         frame_width  = WIDTH_RESET;
         frame_height = HEIGHT_RESET;
      end else begin
         // check first: a pixel never comes from a command accepted at the same edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            check_pixel();
         end
         if (req_chan.valid && req_chan.ready) begin
            predict_pixel(req_chan.command, req_chan.start_x, req_chan.start_y,
                          req_chan.end_x, req_chan.end_y, req_chan.line_color);
         end
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_SCREEN_WIDTH:  frame_width  = csr_chan.data;
               CSR_SCREEN_HEIGHT: frame_height = csr_chan.data;
               default: ;
            endcase
         end
      end
   end

   // result side: random stalls, forced low during a hold-off
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset || hold_active) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // offer one command, with a random idle gap first; returns at its transfer edge
   // valid stays high so back-to-back commands follow with no gap
   task automatic send_item(input logic cmd,
                            input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
                            input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey,
                            input logic [COLOR_BITS-1:0] color);
      if ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_chan.valid      <= 1'b1;
      req_chan.command    <= cmd;
      req_chan.start_x    <= sx;
      req_chan.start_y    <= sy;
      req_chan.end_x      <= ex;
      req_chan.end_y      <= ey;
      req_chan.line_color <= color;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // next-pixel command, endpoint fields carry junk the block must ignore
   task automatic send_step();
      send_item(CMD_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom);
   endtask

   // wait for every predicted pixel, then for any division still running
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one register write; the caller lowers valid afterwards
   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] reg_index, input int value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= reg_index;
      csr_chan.data  <= DIM_BITS'(value);
      do @(posedge clock); while (!csr_chan.ready);
   endtask

   // frame geometry is only changed with the block idle
   task automatic set_geometry(input int width, input int height);
      drain_pipeline();
      write_register(CSR_SCREEN_WIDTH, width);
      write_register(CSR_SCREEN_HEIGHT, height);
      csr_chan.valid <= 1'b0;
   endtask

   // endpoint near an origin, kept on the coordinate grid
   function automatic int near_coordinate(input int origin, input int span);
      int d;
      d = $urandom_range(span);
      if ($urandom_range(1)) begin
         d = -d;
      end
      d = origin + d;
      if (d < 0) begin
         d = 0;
      end
      if (d > (1 << COORD_BITS) - 1) begin
         d = (1 << COORD_BITS) - 1;
      end
      return d;
   endfunction

   // one traffic phase: mostly whole lines with random content, some noise,
   // some lines cut short by a new start and some with extra steps past the end
   task automatic run_random_phase(input int width, input int height,
                                   input int idle, input int stall, input int budget);
      int sent;
      int roll;
      int span;
      int sx;
      int sy;
      int ex;
      int ey;
      int adx;
      int ady;
      int len;
      int count;
      set_geometry(width, height);
      idle_pct  = idle;
      stall_pct = stall;
      sent      = 0;
      while (sent < budget) begin
         roll = $urandom_range(99);
         if (roll < 12) begin
            // noise: either command with all fields random
            send_item(1'($urandom_range(1)), COORD_BITS'($urandom), COORD_BITS'($urandom),
                      COORD_BITS'($urandom), COORD_BITS'($urandom), $urandom);
            sent++;
         end else begin
            roll = $urandom_range(99);
            // mostly short lines, a few medium, rarely across the whole grid
            span = (roll < 85) ? 12 : ((roll < 97) ? 60 : (1 << COORD_BITS) - 1);
            sx   = $urandom_range((1 << COORD_BITS) - 1);
            sy   = $urandom_range((1 << COORD_BITS) - 1);
            ex   = near_coordinate(sx, span);
            ey   = near_coordinate(sy, span);
            adx  = (ex > sx) ? ex - sx : sx - ex;
            ady  = (ey > sy) ? ey - sy : sy - ey;
            len  = (adx >= ady) ? adx : ady;
            send_item(CMD_START, COORD_BITS'(sx), COORD_BITS'(sy),
                      COORD_BITS'(ex), COORD_BITS'(ey), $urandom);
            sent++;
            count = ($urandom_range(3) != 0) ? len + $urandom_range(2) : $urandom_range(len);
            if (count > budget - sent) begin
               count = budget - sent;
            end
            repeat (count) send_step();
            sent += count;
         end
      end
   endtask

   // step right after reset: nothing pending, nothing comes out
   task automatic test_step_without_line();
      send_step();
   endtask

   // short lines at the corners of the grid, both color extremes, extra step past the end
   task automatic test_short_lines();
      send_item(CMD_START, 0, 0, 3, 1, '0);
      repeat (4) send_step();
      send_item(CMD_START, 1023, 1023, 1020, 1021, '1);
      repeat (3) send_step();
   endtask

   // off-screen at reset geometry, with an exact half-pixel increment on y
   task automatic test_off_screen();
      send_item(CMD_START, 700, 1022, 702, 1023, 32'h5a5a_a5a5);
      repeat (2) send_step();
   endtask

   // zero-length line draws nothing
   task automatic test_zero_length();
      send_item(CMD_START, 0, 0, 0, 0, 32'h0123_4567);
      send_step();
   endtask

   // a start while a line is still running replaces it
   task automatic test_line_restart();
      send_item(CMD_START, 0, 1023, 2, 1020, 32'hdead_beef);
      send_step();
      send_item(CMD_START, 1021, 1, 1023, 0, 32'hcafe_f00d);
      repeat (2) send_step();
   endtask

   // register extremes first, then random geometry, across all idle profiles
   task automatic test_random_traffic();
      int idle_profile[4];
      int stall_profile[4];
      idle_profile  = '{0, 73, 0, 35};
      stall_profile = '{0, 0, 73, 35};
      run_random_phase(1, 1, idle_profile[0], stall_profile[0], 125);
      run_random_phase(1024, 1024, idle_profile[1], stall_profile[1], 125);
      // zero geometry: in_bounds always low
      run_random_phase(0, 0, idle_profile[2], stall_profile[2], 125);
      run_random_phase(2047, 2047, idle_profile[3], stall_profile[3], 125);
      for (int k = 0; k < 4; k++) begin
         run_random_phase($urandom_range(1, 1024), $urandom_range(1, 1024),
                          idle_profile[k], stall_profile[k], 125);
      end
   endtask

   // receiver holds off while steps keep coming, so the block backs up into its input
   task automatic test_output_backpressure();
      set_geometry(640, 480);
      idle_pct  = 0;
      stall_pct = 0;
      send_item(CMD_START, 10, 20, 60, 40, $urandom);
      fork
         begin
            @(posedge clock);
            hold_active <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end
         begin
            repeat (50) send_step();
         end
      join
   endtask

   initial begin
      reset               <= 1'b1;
      hold_active         <= 1'b0;
      req_chan.valid      <= 1'b0;
      req_chan.command    <= CMD_START;
      req_chan.start_x    <= '0;
      req_chan.start_y    <= '0;
      req_chan.end_x      <= '0;
      req_chan.end_y      <= '0;
      req_chan.line_color <= '0;
      csr_chan.valid      <= 1'b0;
      csr_chan.index      <= CSR_SCREEN_WIDTH;
      csr_chan.data       <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_step_without_line();
      test_short_lines();
      test_off_screen();
      test_zero_length();
      test_line_restart();
      test_random_traffic();
      test_output_backpressure();

      // all stimulus accepted: let the last pixels and divisions finish
      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, several times the slowest expected run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire
